>>> design/sstv_nco_pkg.sv
`default_nettype none

package sstv_nco_pkg;

   // Field widths of the request and response items.
   localparam int TYPE_BITS   = 2;
   localparam int VALUE_BITS  = 12;
   localparam int SAMPLE_BITS = 16;

   // Request kinds; the fourth code behaves as silence.
   localparam logic [TYPE_BITS-1:0] KIND_SILENCE = 2'd0;
   localparam logic [TYPE_BITS-1:0] KIND_TONE    = 2'd1;
   localparam logic [TYPE_BITS-1:0] KIND_LEVEL   = 2'd2;

   // Frequency in Q8 Hz and the phase step register.
   localparam int FREQ_BITS       = 20;
   localparam int STEP_BITS       = 29;
   localparam int MAX_PHASE_BITS  = 48;
   localparam logic [STEP_BITS-1:0] STEP_RESET = 29'd22906492;

   // Pixel level mapping: 1500 Hz plus 800*level/255 Hz, in Q8 Hz.
   localparam int LEVEL_BITS      = 8;
   localparam int LEVEL_COUNT     = 1 << LEVEL_BITS;
   localparam int LEVEL_MAX       = 255;
   localparam int LEVEL_SPAN_Q8   = 204800;
   localparam int LEVEL_OFS_BITS  = 18;
   localparam logic [FREQ_BITS-1:0] LEVEL_BASE_Q8 = 20'd384000;

   // Cosine table: quarter wave, magnitudes only.
   localparam int SINE_ADDR_BITS  = 10;
   localparam int QUARTER_BITS    = SINE_ADDR_BITS - 2;
   localparam int QUARTER         = 1 << QUARTER_BITS;
   localparam int COS_MAG_BITS    = 15;
   localparam logic [63:0] AMPLITUDE   = 64'd22937;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1073741824;

   // Configuration register map (word index taken from paddr[2]).
   localparam int CSR_ADDR_BITS = 3;
   localparam logic CSR_IDX_PHASE_STEP = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE
   } state_type;

   typedef logic [QUARTER-1:0][COS_MAG_BITS-1:0]       cos_table_type;
   typedef logic [LEVEL_COUNT-1:0][LEVEL_OFS_BITS-1:0] level_table_type;

   // Scaled cosine magnitude at idx quarter-steps, Q30 Taylor series.
   function automatic logic [COS_MAG_BITS-1:0] cos_mag(input int unsigned idx);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        mag;
      logic signed [63:0] sum;
      x    = (64'(idx) * HALF_PI_Q30) >> QUARTER_BITS;
      x2   = (x * x) >> 30;
      term = ONE_Q30;
      sum  = $signed(ONE_Q30);
      term = ((term * x2) >> 30) / 64'd2;   sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd12;  sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd30;  sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd56;  sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd90;  sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd132; sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd182; sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd240; sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd306; sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd380; sum = sum + $signed(term);
      if (sum < 0) begin
         mag = $unsigned(-sum);
      end else begin
         mag = $unsigned(sum);
      end
      mag = (mag * AMPLITUDE + (ONE_Q30 >> 1)) >> 30;
      return mag[COS_MAG_BITS-1:0];
   endfunction

   function automatic cos_table_type build_cos_table();
      cos_table_type tbl;
      for (int i = 0; i < QUARTER; i++) begin
         tbl[i] = cos_mag(i);
      end
      return tbl;
   endfunction

   function automatic level_table_type build_level_table();
      level_table_type tbl;
      for (int i = 0; i < LEVEL_COUNT; i++) begin
         tbl[i] = LEVEL_OFS_BITS'((LEVEL_SPAN_Q8 * i + 127) / LEVEL_MAX);
      end
      return tbl;
   endfunction

   localparam cos_table_type   COS_TABLE   = build_cos_table();
   localparam level_table_type LEVEL_TABLE = build_level_table();

endpackage

`default_nettype wire

>>> design/sstv_nco_if.sv
`default_nettype none

interface sstv_nco_req_if import sstv_nco_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [TYPE_BITS-1:0]  req_type;
   logic [VALUE_BITS-1:0] tone_value;

   modport source (output valid, output req_type, output tone_value, input ready);
   modport sink   (input valid, input req_type, input tone_value, output ready);
endinterface

interface sstv_nco_rsp_if import sstv_nco_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

>>> design/sstv_nco_ram.sv
`default_nettype none

module sstv_nco_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/sstv_tone_nco_modulator_unit.sv
// A request accepted in the idle state passes through the read and update states, and
// its sample is then held in the output register until the sink takes it.
// A new request is taken only in the idle state, after the read, update and write-back
// of the phase word in its synchronous memory; a full output register adds stall.
// Reset (synchronous, active high) sets phase_step to its 48 kHz value, marks the
// phase word unwritten so it reads as a three-quarter turn, and empties the output.
`default_nettype none

module sstv_tone_nco_modulator_unit import sstv_nco_pkg::*; #(
   parameter int PHASE_BITS = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   sstv_nco_req_if.sink                  req_if,
   sstv_nco_rsp_if.source                rsp_if,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [31:0]              pwdata,
   output logic      [31:0]              prdata,
   output logic                          pready
);

   // The product of a Q8 frequency and the step is scaled by 2^-48 turns; with
   // fewer phase bits the low bits are dropped.
   localparam int PROD_BITS   = FREQ_BITS + STEP_BITS;
   localparam int PROD_SHIFT  = MAX_PHASE_BITS - PHASE_BITS;
   localparam int PHASE_DEPTH = 1;
   localparam int PHASE_ABITS = 1;
   localparam logic [PHASE_ABITS-1:0] PHASE_ADDR = '0;
   localparam logic [PHASE_BITS-1:0]  PHASE_RESET = {2'b11, {(PHASE_BITS-2){1'b0}}};

   // Control state.
   state_type                      state_ff, state_in;
   logic                           phase_valid_ff, phase_valid_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [STEP_BITS-1:0]           step_ff, step_in;

   // Per-request payload.
   logic                           active_ff, active_in;
   logic [FREQ_BITS-1:0]           freq_ff, freq_in;
   logic [PHASE_BITS-1:0]          phase_ff, phase_in;
   logic [PHASE_BITS-1:0]          inc_ff, inc_in;
   logic signed [SAMPLE_BITS-1:0]  sample_ff, sample_in;

   // Handshake and memory controls.
   logic                           req_accept;
   logic                           out_free;
   logic                           ram_rd_en;
   logic                           ram_wr_en;
   logic [PHASE_BITS-1:0]          ram_rd_data;
   logic                           csr_write;

   // Datapath intermediates.
   logic [LEVEL_BITS-1:0]          level;
   logic [PHASE_BITS-1:0]          phase_cur;
   logic [PROD_BITS-1:0]           product;
   logic [SINE_ADDR_BITS-1:0]      table_addr;
   logic [1:0]                     quadrant;
   logic [QUARTER_BITS-1:0]        remainder;
   logic [QUARTER_BITS-1:0]        table_idx;
   logic [COS_MAG_BITS-1:0]        cos_magnitude;
   logic [SAMPLE_BITS-1:0]         mag_ext;
   logic signed [SAMPLE_BITS-1:0]  cos_sample;

   // The phase accumulator lives in a one-entry synchronous memory. It is read
   // when a request is accepted and written back in the update state; requests
   // are interlocked so a read never overlaps a pending write.
   sstv_nco_ram #(
      .WIDTH (PHASE_BITS),
      .DEPTH (PHASE_DEPTH)
   ) u_phase_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (PHASE_ADDR),
      .wr_data (phase_ff + inc_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (PHASE_ADDR),
      .rd_data (ram_rd_data)
   );

   // Configuration port. Writes complete in the access phase; pready is tied high.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign prdata    = (paddr[2] == CSR_IDX_PHASE_STEP) ? {{(32-STEP_BITS){1'b0}}, step_ff}
                                                       : 32'd0;

   always_comb begin
      step_in = step_ff;
      if (csr_write && paddr[2] == CSR_IDX_PHASE_STEP) begin
         step_in = pwdata[STEP_BITS-1:0];
      end
   end

   assign req_accept = req_if.valid && req_if.ready;
   assign out_free   = !rsp_valid_ff || rsp_if.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State outputs. No request is taken while reset is held.
   always_comb begin
      req_if.ready = 1'b0;
      ram_rd_en    = 1'b0;
      ram_wr_en    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_if.ready = !reset;
            ram_rd_en    = req_accept;
         end
         ST_READ: begin
         end
         ST_UPDATE: begin
            ram_wr_en = out_free && active_ff;
         end
         default: begin
         end
      endcase
   end

   // Request decode: a tone is whole Hz shifted into Q8, a pixel level is looked
   // up in the level table after saturating to full white. Silence and the unused
   // code leave the phase alone.
   assign level = (req_if.tone_value > VALUE_BITS'(LEVEL_MAX)) ? LEVEL_BITS'(LEVEL_MAX)
                                                                : req_if.tone_value[LEVEL_BITS-1:0];

   always_comb begin
      active_in = active_ff;
      freq_in   = freq_ff;
      if (state_ff == ST_IDLE && req_accept) begin
         case (req_if.req_type)
            KIND_TONE: begin
               active_in = 1'b1;
               freq_in   = {req_if.tone_value, 8'd0};
            end
            KIND_LEVEL: begin
               active_in = 1'b1;
               freq_in   = LEVEL_BASE_Q8 + FREQ_BITS'(LEVEL_TABLE[level]);
            end
            default: begin
               active_in = 1'b0;
               freq_in   = freq_ff;
            end
         endcase
      end
   end

   // Read cycle: the phase word arrives from memory (or its reset value if it
   // was never written), and the increment is formed by one multiplier.
   assign phase_cur = phase_valid_ff ? ram_rd_data : PHASE_RESET;
   assign product   = PROD_BITS'(freq_ff) * PROD_BITS'(step_ff);

   always_comb begin
      phase_in = phase_ff;
      inc_in   = inc_ff;
      if (state_ff == ST_READ) begin
         phase_in = phase_cur;
         inc_in   = PHASE_BITS'(product >> PROD_SHIFT);
      end
   end

   // Cosine lookup from the top bits of the phase. Only the first quarter is
   // stored; odd quarters read the table mirrored, and the exact quarter point
   // of an odd quarter is the zero crossing. The middle two quarters are negative.
   assign table_addr    = phase_ff[PHASE_BITS-1 -: SINE_ADDR_BITS];
   assign quadrant      = table_addr[SINE_ADDR_BITS-1 -: 2];
   assign remainder     = table_addr[QUARTER_BITS-1:0];
   assign table_idx     = quadrant[0] ? (QUARTER_BITS'(0) - remainder) : remainder;
   assign cos_magnitude = (quadrant[0] && remainder == '0) ? '0 : COS_TABLE[table_idx];
   assign mag_ext       = {{(SAMPLE_BITS-COS_MAG_BITS){1'b0}}, cos_magnitude};
   assign cos_sample    = (quadrant[1] ^ quadrant[0]) ? -$signed(mag_ext) : $signed(mag_ext);

   // Output register and phase-written flag.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      sample_in      = sample_ff;
      phase_valid_in = phase_valid_ff;
      if (state_ff == ST_UPDATE && out_free) begin
         rsp_valid_in = 1'b1;
         sample_in    = active_ff ? cos_sample : '0;
         if (active_ff) begin
            phase_valid_in = 1'b1;
         end
      end
   end

   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.sample = sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         phase_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         step_ff        <= STEP_RESET;
      end else begin
         state_ff       <= state_in;
         phase_valid_ff <= phase_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         step_ff        <= step_in;
      end
      active_ff <= active_in;
      freq_ff   <= freq_in;
      phase_ff  <= phase_in;
      inc_ff    <= inc_in;
      sample_ff <= sample_in;
   end

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`default_nettype none

module tb_top;
   import sstv_nco_pkg::*;

   // The fourth request code has no name in the package; it must behave as silence.
   localparam logic [TYPE_BITS-1:0] KIND_SPARE = 2'd3;

   // Register map: phase_step is word 0; word 1 is unused and must ignore writes.
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_PHASE_STEP = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_UNUSED     = 3'd4;

   // Percentage of cycles in which a side holds off when idling is allowed.
   localparam int IDLE_PCT = 11;

   // Cosine table geometry and scaling used by the sample predictor.
   localparam longint unsigned TABLE_QUARTER = 64'd256;
   localparam longint unsigned PI_HALF_Q30   = 64'd1686629713;
   localparam longint unsigned UNIT_Q30      = 64'd1073741824;
   localparam longint unsigned PEAK          = 64'd22937;

   typedef struct packed {
      logic [TYPE_BITS-1:0]  kind;
      logic [VALUE_BITS-1:0] value;
   } tone_request_type;

   logic                     clock   = 1'b0;
   logic                     reset   = 1'b1;
   logic                     psel    = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr   = '0;
   logic [31:0]              pwdata  = '0;
   wire  [31:0]              prdata;
   wire                      pready;

   sstv_nco_req_if req_bus ();
   sstv_nco_rsp_if rsp_bus ();

   sstv_tone_nco_modulator_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_bus),
      .rsp_if  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Predictor state: our own copy of the phase accumulator and the step register.
   logic [31:0]          nco_phase = 32'hC000_0000;
   logic [STEP_BITS-1:0] nco_step  = STEP_RESET;

   tone_request_type         pending_requests[$];
   logic signed [15:0]       expected_samples[$];
   int                       mismatch_count = 0;
   bit                       no_idle = 1'b0;

   always #4 clock = ~clock;

   // Cosine of idx quarter-steps (idx in 0..256) in Q30, from a quarter-wave Taylor series.
   function automatic longint cos_q30(input longint unsigned idx);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      x    = (idx * PI_HALF_Q30) / TABLE_QUARTER;
      x2   = (x * x) >> 30;
      term = UNIT_Q30;
      sum  = longint'(term);
      for (int n = 0; n < 10; n++) begin
         term = ((term * x2) >> 30) / 64'((2 * n + 1) * (2 * n + 2));
         if (n % 2 == 1) begin
            sum = sum + longint'(term);
         end else begin
            sum = sum - longint'(term);
         end
      end
      return sum;
   endfunction

   // Scaled and rounded table entry for a 10-bit phase address; the sign comes
   // from folding the quadrant onto the first quarter wave.
   function automatic logic signed [15:0] cos_entry(input logic [9:0] k);
      longint          c;
      longint unsigned mag;
      bit              neg;
      if (k[9:8] == 2'd0 || k[9:8] == 2'd2) begin
         c = cos_q30(64'(k[7:0]));
      end else begin
         c = cos_q30(TABLE_QUARTER - 64'(k[7:0]));
      end
      if (k[9:8] == 2'd1 || k[9:8] == 2'd2) begin
         c = -c;
      end
      neg = (c < 0);
      mag = neg ? $unsigned(-c) : $unsigned(c);
      mag = (mag * PEAK + (UNIT_Q30 >> 1)) >> 30;
      return neg ? 16'(64'd0 - mag) : 16'(mag);
   endfunction

   // Expected sample for one accepted request. Tone and level requests read the
   // table at the current phase and then advance the phase; everything else is
   // silence and leaves the phase untouched.
   function automatic logic signed [15:0] advance_tone(input logic [TYPE_BITS-1:0] kind,
                                                       input logic [VALUE_BITS-1:0] value);
      longint unsigned    freq_q8;
      longint unsigned    lvl;
      logic signed [15:0] sample;
      if (kind == KIND_TONE) begin
         freq_q8 = 64'(value) << 8;
      end else if (kind == KIND_LEVEL) begin
         // Levels above full scale saturate at the top of the band.
         lvl     = (value > 12'd255) ? 64'd255 : 64'(value);
         freq_q8 = 64'd384000 + (64'd204800 * lvl + 64'd127) / 64'd255;
      end else begin
         return 16'sd0;
      end
      sample    = cos_entry(nco_phase[31:22]);
      nco_phase = nco_phase + 32'((freq_q8 * 64'(nco_step)) >> 16);
      return sample;
   endfunction

   // Request driver. The request on the bus is predicted at the edge where it is
   // accepted, and the next one is put up in the same step, so valid never drops
   // between back-to-back requests.
   always @(posedge clock) begin : drive_requests
      tone_request_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_samples.push_back(advance_tone(req_bus.req_type, req_bus.tone_value));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_requests.size() != 0 &&
                (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
               nxt = pending_requests.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.req_type   <= nxt.kind;
               req_bus.tone_value <= nxt.value;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor. Each accepted sample is compared with the oldest prediction;
   // ready is dropped at random to stall the output register.
   always @(posedge clock) begin : check_samples
      logic signed [15:0] want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_samples.size() == 0) begin
               $error("sample: expected none, actual %0d", rsp_bus.sample);
               mismatch_count++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_bus.sample !== want) begin
                  $error("sample: expected %0d, actual %0d", want, rsp_bus.sample);
                  mismatch_count++;
               end
            end
         end
         rsp_bus.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   task automatic queue_request(input logic [TYPE_BITS-1:0] kind,
                                input logic [VALUE_BITS-1:0] value);
      tone_request_type item;
      item.kind  = kind;
      item.value = value;
      pending_requests.push_back(item);
   endtask

   // Random requests: mostly tones and in-range pixel levels, with some silence,
   // some of the spare code and some out-of-range levels mixed in.
   task automatic queue_random(input int count);
      int                    sel;
      logic [TYPE_BITS-1:0]  kind;
      logic [VALUE_BITS-1:0] value;
      for (int i = 0; i < count; i++) begin
         sel   = $urandom_range(99);
         value = VALUE_BITS'($urandom_range(4095));
         if (sel < 8) begin
            kind = KIND_SILENCE;
         end else if (sel < 14) begin
            kind = KIND_SPARE;
         end else if (sel < 55) begin
            kind = KIND_TONE;
         end else begin
            kind = KIND_LEVEL;
            if ($urandom_range(9) != 0) begin
               value = VALUE_BITS'($urandom_range(255));
            end
         end
         queue_request(kind, value);
      end
   endtask

   // Wait until every queued request has gone in and every sample has come out,
   // then let the pipeline settle before touching the register.
   // The queues are checked at the falling edge, after the clocked blocks settle.
   task automatic drain();
      while (pending_requests.size() != 0 || req_bus.valid || expected_samples.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // Register write: a setup cycle, then an access cycle held until pready.
   task automatic write_csr(input logic [CSR_ADDR_BITS-1:0] addr, input logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == ADDR_PHASE_STEP) begin
         nco_step = data[STEP_BITS-1:0];
      end
   endtask

   initial begin : stimulus
      req_bus.valid      = 1'b0;
      req_bus.req_type   = KIND_SILENCE;
      req_bus.tone_value = '0;
      rsp_bus.ready      = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // First phase runs on the reset step (48 kHz). The first tone request must
      // read the table at the three-quarter turn, where the cosine is zero.
      queue_request(KIND_SILENCE, 12'hFFF);
      queue_request(KIND_TONE,    12'd0);
      queue_request(KIND_TONE,    12'd4095);
      queue_request(KIND_SPARE,   12'h5A5);
      queue_request(KIND_TONE,    12'd1200);
      queue_request(KIND_TONE,    12'd1900);
      queue_request(KIND_TONE,    12'd2300);
      queue_request(KIND_TONE,    12'd1);
      queue_request(KIND_LEVEL,   12'd0);
      queue_request(KIND_LEVEL,   12'd128);
      queue_request(KIND_LEVEL,   12'd255);
      queue_request(KIND_LEVEL,   12'd256);
      queue_request(KIND_LEVEL,   12'd4095);
      drain();

      // A zero step freezes the phase, yet tone and level requests still read the table.
      write_csr(ADDR_PHASE_STEP, 32'd0);
      queue_request(KIND_TONE,  12'd1900);
      queue_request(KIND_LEVEL, 12'd200);
      queue_request(KIND_TONE,  12'd4095);
      queue_request(KIND_SPARE, 12'd0);
      drain();

      // A write to the unused word must leave the step alone; then the smallest step.
      write_csr(ADDR_UNUSED, 32'h0ABC_DEF1);
      write_csr(ADDR_PHASE_STEP, 32'd1);
      queue_request(KIND_TONE,  12'd4095);
      queue_request(KIND_TONE,  12'd4095);
      queue_request(KIND_LEVEL, 12'd255);
      queue_random(20);
      drain();

      // Largest step in the documented range, then all ones so that the upper
      // bits of the write data are dropped and the full 29-bit field is used.
      write_csr(ADDR_PHASE_STEP, 32'h1000_0000);
      queue_random(60);
      drain();
      write_csr(ADDR_PHASE_STEP, 32'hFFFF_FFFF);
      queue_random(40);
      drain();

      // Back at the 48 kHz step, a long stretch with neither side holding off,
      // so the block runs at its full rate.
      no_idle = 1'b1;
      write_csr(ADDR_PHASE_STEP, 32'(STEP_RESET));
      queue_random(100);
      drain();
      no_idle = 1'b0;

      // Random steps over the documented range. Each drain also makes the sender
      // wait for every outstanding sample before the next phase starts.
      for (int p = 0; p < 6; p++) begin
         write_csr(ADDR_PHASE_STEP, 32'($urandom_range(268435456, 1)));
         queue_random(45);
         drain();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin : watchdog
      #(8 * 200000);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
